[rtl/core/nested_priority_task_queue_defines.svh]
// assertion macros shared by the priority task queue rtl
`ifndef NESTED_PRIORITY_TASK_QUEUE_DEFINES_SVH
`define NESTED_PRIORITY_TASK_QUEUE_DEFINES_SVH

// condition must hold in the same cycle
`define NPTQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the following cycle
`define NPTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/nptq_pkg.sv]
// shared types and constants of the nested priority task queue
`timescale 1ns / 1ps

package nptq_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int NEST_DEPTH_DEF  = 8;

    localparam logic [8:0] IDLE_LEVEL = 9'd256;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_QUEUE_FULL = 2'd1;
    localparam logic [1:0] ST_IDLE_FIN   = 2'd2;
    localparam logic [1:0] ST_NEST_FULL  = 2'd3;

    typedef struct packed {
        logic       opcode;
        logic [7:0] task_id;
        logic [7:0] task_level;
    } req_item_t;

    typedef struct packed {
        logic       dispatch_valid;
        logic [7:0] dispatch_id;
        logic [7:0] dispatch_level;
        logic [1:0] status;
        logic [3:0] pending_count;
        logic [8:0] running_level;
    } rsp_item_t;

    typedef struct packed {
        logic [7:0] id;
        logic [7:0] level;
    } entry_t;

    // queue cell operation
    typedef enum logic [1:0] {
        QOP_HOLD   = 2'd0,
        QOP_INSERT = 2'd1,
        QOP_POP    = 2'd2
    } qop_t;

    // stack cell operation
    typedef enum logic [1:0] {
        SOP_HOLD = 2'd0,
        SOP_PUSH = 2'd1,
        SOP_POP  = 2'd2
    } sop_t;

    typedef struct packed {
        qop_t   op;
        entry_t item;
    } qcell_ctl_t;

endpackage

[rtl/core/nptq_qcell.sv]
// one slot of the sorted pending-task shift chain
`timescale 1ns / 1ps

module nptq_qcell
    import nptq_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 4
)
(
    input  logic             clk,
    input  qcell_ctl_t       ctl,
    input  logic [CNT_W-1:0] total,
    input  logic             prev_keep,
    input  entry_t           prev_entry,
    input  entry_t           next_entry,
    output logic             keep,
    output entry_t           entry
);

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    entry_t entry_reg;
    entry_t entry_next;

    // occupied and not larger than the new item: stays in place on insert
    assign keep  = (IDX_C < total) && (entry_reg.level <= ctl.item.level);
    assign entry = entry_reg;

    // shift right on insert, shift left on pop
    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctl.op)
            QOP_INSERT:
            begin
                if (keep)
                begin
                    entry_next = entry_reg;
                end
                else if (prev_keep)
                begin
                    entry_next = ctl.item;
                end
                else
                begin
                    entry_next = prev_entry;
                end
            end
            QOP_POP:  entry_next = next_entry;
            default:  entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

[rtl/core/nptq_scell.sv]
// one slot of the shifting stack of preempted levels
`timescale 1ns / 1ps

module nptq_scell
    import nptq_pkg::*;
(
    input  logic       clk,
    input  sop_t       op,
    input  logic [8:0] prev_level,
    input  logic [8:0] next_level,
    output logic [8:0] level
);

    logic [8:0] level_reg;
    logic [8:0] level_next;

    assign level = level_reg;

    // push moves away from the top, pop moves toward it
    always_comb
    begin
        unique case (op)
            SOP_PUSH: level_next = prev_level;
            SOP_POP:  level_next = next_level;
            default:  level_next = level_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        level_reg <= level_next;
    end

endmodule

[rtl/core/nested_priority_task_queue.sv]
// Nested priority task queue: sorted pending tasks and a stack of preempted levels.
//
// Request channel req (req_valid/req_ready) carries an add or a finish item;
// response channel rsp (rsp_valid/rsp_ready) returns one result per item.
// Pending tasks sit in a chain of QUEUE_DEPTH cells kept sorted by level
// (equal levels first in, first out); preempted levels sit in a chain of
// NEST_DEPTH stack cells whose first cell is the top.
// Each item passes through S_EXEC, which inserts into the queue chain or pops the
// stack chain, and then S_DISP, which checks the queue head against the running
// level and possibly pops the head and pushes the old level. The result lands in
// the output register as S_DISP ends, and the next item is taken in the same
// cycle, so a new item enters only once the previous item has written its result.
// A result waiting in the output register does not block the next item's
// S_EXEC step; its S_DISP step waits until the register is free, so a
// stalled receiver stalls the block after at most one more accepted item.
// Reset empties the queue and stack and sets the running level to idle (256).
`timescale 1ns / 1ps
`include "nested_priority_task_queue_defines.svh"

module nested_priority_task_queue
    import nptq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int NEST_DEPTH  = NEST_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int DEP_W = $clog2(NEST_DEPTH + 1);
    localparam logic [CNT_W-1:0] QUEUE_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [DEP_W-1:0] NEST_FULL  = DEP_W'(NEST_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DISP = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    req_item_t        item_reg, item_next;
    logic [1:0]       status_reg, status_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [8:0]       cur_reg, cur_next;
    logic [DEP_W-1:0] depth_reg, depth_next;
    rsp_item_t        out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    qcell_ctl_t       qctl;
    sop_t             sop;
    entry_t           q_entry [QUEUE_DEPTH];
    logic             q_keep  [QUEUE_DEPTH];
    logic [8:0]       s_level [NEST_DEPTH];

    logic             can_out;
    logic             due;
    logic             fired;
    logic [1:0]       disp_status;

    assign can_out   = !out_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE) || ((state_reg == S_DISP) && can_out);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // pending task chain
    for (genvar k = 0; k < QUEUE_DEPTH; k++)
    begin : g_q
        logic   pk;
        entry_t pe;
        entry_t ne;
        if (k == 0)
        begin : g_first
            assign pk = 1'b1;
            assign pe = qctl.item;
        end
        else
        begin : g_mid
            assign pk = q_keep[k-1];
            assign pe = q_entry[k-1];
        end
        if (k == QUEUE_DEPTH - 1)
        begin : g_last
            assign ne = qctl.item;
        end
        else
        begin : g_body
            assign ne = q_entry[k+1];
        end
        nptq_qcell #(
            .IDX   (k),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .ctl        (qctl),
            .total      (total_reg),
            .prev_keep  (pk),
            .prev_entry (pe),
            .next_entry (ne),
            .keep       (q_keep[k]),
            .entry      (q_entry[k])
        );
    end

    // preempted level chain
    for (genvar k = 0; k < NEST_DEPTH; k++)
    begin : g_s
        logic [8:0] pl;
        logic [8:0] nl;
        if (k == 0)
        begin : g_top
            assign pl = cur_reg;
        end
        else
        begin : g_mid
            assign pl = s_level[k-1];
        end
        if (k == NEST_DEPTH - 1)
        begin : g_bottom
            assign nl = cur_reg;
        end
        else
        begin : g_body
            assign nl = s_level[k+1];
        end
        nptq_scell u_cell (
            .clk        (clk),
            .op         (sop),
            .prev_level (pl),
            .next_level (nl),
            .level      (s_level[k])
        );
    end

    // head more urgent than the running level
    assign due   = (total_reg != '0) && ({1'b0, q_entry[0].level} < cur_reg);
    assign fired = due && (depth_reg < NEST_FULL);
    assign disp_status = (due && !fired && (status_reg == ST_OK)) ? ST_NEST_FULL
                                                                   : status_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        status_next    = status_reg;
        total_next     = total_reg;
        cur_next       = cur_reg;
        depth_next     = depth_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        qctl.op        = QOP_HOLD;
        qctl.item.id   = item_reg.task_id;
        qctl.item.level = item_reg.task_level;
        sop            = SOP_HOLD;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next  = req;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                status_next = ST_OK;
                if (item_reg.opcode == OP_ADD)
                begin
                    if (total_reg >= QUEUE_FULL)
                    begin
                        status_next = ST_QUEUE_FULL;
                    end
                    else
                    begin
                        qctl.op    = QOP_INSERT;
                        total_next = total_reg + 1'b1;
                    end
                end
                else
                begin
                    if (depth_reg == '0)
                    begin
                        status_next = ST_IDLE_FIN;
                    end
                    else
                    begin
                        sop        = SOP_POP;
                        cur_next   = s_level[0];
                        depth_next = depth_reg - 1'b1;
                    end
                end
                state_next = S_DISP;
            end
            S_DISP:
            begin
                if (can_out)
                begin
                    if (fired)
                    begin
                        qctl.op    = QOP_POP;
                        sop        = SOP_PUSH;
                        cur_next   = {1'b0, q_entry[0].level};
                        total_next = total_reg - 1'b1;
                        depth_next = depth_reg + 1'b1;
                    end
                    out_next.dispatch_valid = fired;
                    out_next.dispatch_id    = fired ? q_entry[0].id : 8'd0;
                    out_next.dispatch_level = fired ? q_entry[0].level : 8'd0;
                    out_next.status         = disp_status;
                    out_next.pending_count  = 4'(total_next);
                    out_next.running_level  = cur_next;
                    out_valid_next          = 1'b1;
                    if (req_valid)
                    begin
                        item_next  = req;
                        state_next = S_EXEC;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            cur_reg       <= IDLE_LEVEL;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            cur_reg       <= cur_next;
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        status_reg <= status_next;
        out_reg    <= out_next;
    end

    `NPTQ_ASSERT_SAME(a_total_bound, 1'b1, total_reg <= QUEUE_FULL,
        "pending count above queue depth")
    `NPTQ_ASSERT_SAME(a_depth_bound, 1'b1, depth_reg <= NEST_FULL,
        "nesting depth above stack size")
    `NPTQ_ASSERT_NEXT(a_accept_exec, req_valid && req_ready, state_reg == S_EXEC,
        "accepted item did not start")
    `NPTQ_ASSERT_SAME(a_disp_level, out_valid_reg && out_reg.dispatch_valid,
        out_reg.running_level == {1'b0, out_reg.dispatch_level},
        "dispatched level is not the running level")
    `NPTQ_ASSERT_SAME(a_head_sorted, (state_reg != S_EXEC) && (total_reg >= CNT_W'(2)),
        q_entry[0].level <= q_entry[1].level, "queue head out of order")

endmodule

[tb/tb_nested_priority_task_queue.sv]
// self-checking testbench for the nested priority task queue
`timescale 1ns / 1ps

module tb_nested_priority_task_queue;
    import nptq_pkg::*;

    localparam int QD = QUEUE_DEPTH_DEF;
    localparam int ND = NEST_DEPTH_DEF;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    req_item_t req;
    logic      rsp_valid;
    logic      rsp_ready;
    rsp_item_t rsp;

    // shadow state of the scheduler
    logic [7:0] shadow_id [QD];
    logic [7:0] shadow_lvl [QD];
    int         shadow_count;
    logic [8:0] shadow_run_level;
    logic [8:0] shadow_saved [ND];
    int         shadow_depth;

    rsp_item_t  expected_dispatch_q [$];
    int         error_count;
    int         items_sent;
    int         dispatch_seen;
    int         status_seen [4];
    bit         src_idle_en;
    bit         sink_idle_en;

    nested_priority_task_queue #(
        .QUEUE_DEPTH (QD),
        .NEST_DEPTH  (ND)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // clock
    always #5 clk = ~clk;

    // overall time limit
    initial
    begin
        #(5_000_000);
        $display("timeout with %0d items still expected", expected_dispatch_q.size());
        $display("*** FAILED ***");
        $finish;
    end

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // work out the result of one event and advance the shadow state
    function automatic rsp_item_t schedule_event(input req_item_t it);
        rsp_item_t  r;
        logic [1:0] st;
        int         pos;
        r = '0;
        st = ST_OK;
        // add or finish
        if (it.opcode == OP_ADD)
        begin
            if (shadow_count >= QD)
                st = ST_QUEUE_FULL;
            else
            begin
                pos = 0;
                while (pos < shadow_count && shadow_lvl[pos] <= it.task_level)
                    pos++;
                for (int k = shadow_count; k > pos; k--)
                begin
                    shadow_id[k]  = shadow_id[k - 1];
                    shadow_lvl[k] = shadow_lvl[k - 1];
                end
                shadow_id[pos]  = it.task_id;
                shadow_lvl[pos] = it.task_level;
                shadow_count++;
            end
        end
        else
        begin
            if (shadow_depth == 0)
                st = ST_IDLE_FIN;
            else
            begin
                shadow_depth--;
                shadow_run_level = shadow_saved[shadow_depth];
            end
        end
        // preempt when the head is strictly more urgent
        if (shadow_count > 0 && {1'b0, shadow_lvl[0]} < shadow_run_level)
        begin
            if (shadow_depth >= ND)
            begin
                if (st == ST_OK)
                    st = ST_NEST_FULL;
            end
            else
            begin
                shadow_saved[shadow_depth] = shadow_run_level;
                shadow_depth++;
                r.dispatch_valid = 1'b1;
                r.dispatch_id    = shadow_id[0];
                r.dispatch_level = shadow_lvl[0];
                shadow_run_level = {1'b0, shadow_lvl[0]};
                for (int k = 1; k < shadow_count; k++)
                begin
                    shadow_id[k - 1]  = shadow_id[k];
                    shadow_lvl[k - 1] = shadow_lvl[k];
                end
                shadow_count--;
            end
        end
        r.status        = st;
        r.pending_count = shadow_count[3:0];
        r.running_level = shadow_run_level;
        return r;
    endfunction

    function automatic req_item_t make_event(input logic op, input logic [7:0] id,
                                             input logic [7:0] lvl);
        req_item_t it;
        it.opcode     = op;
        it.task_id    = id;
        it.task_level = lvl;
        return it;
    endfunction

    // level mix with extremes and clustered ties
    function automatic logic [7:0] pick_level();
        logic [7:0] lvl;
        case ($urandom_range(0, 9))
            0: lvl = 8'd0;
            1: lvl = 8'd255;
            2, 3: lvl = 8'($urandom_range(100, 103));
            default: lvl = 8'($urandom_range(0, 255));
        endcase
        return lvl;
    endfunction

    // present one item and wait for it to be taken
    task automatic send_event(input req_item_t it);
        if (src_idle_en && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= it;
        do
            @(posedge clk);
        while (!req_ready);
        expected_dispatch_q.push_back(schedule_event(it));
        items_sent++;
    endtask

    // drop valid and hold off until every result is back
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (expected_dispatch_q.size() > 0)
            @(posedge clk);
    endtask

    // receiver stalls in random bursts
    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_idle_en && $urandom_range(0, 5) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            rsp_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        rsp_item_t e;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_dispatch_q.size() == 0)
                flag_error($sformatf("unexpected result %h", rsp));
            else
            begin
                e = expected_dispatch_q.pop_front();
                if (rsp.dispatch_valid !== e.dispatch_valid)
                    flag_error($sformatf("dispatch_valid %b, want %b",
                                         rsp.dispatch_valid, e.dispatch_valid));
                if (rsp.dispatch_id !== e.dispatch_id)
                    flag_error($sformatf("dispatch_id %h, want %h",
                                         rsp.dispatch_id, e.dispatch_id));
                if (rsp.dispatch_level !== e.dispatch_level)
                    flag_error($sformatf("dispatch_level %0d, want %0d",
                                         rsp.dispatch_level, e.dispatch_level));
                if (rsp.status !== e.status)
                    flag_error($sformatf("status %0d, want %0d", rsp.status, e.status));
                if (rsp.pending_count !== e.pending_count)
                    flag_error($sformatf("pending_count %0d, want %0d",
                                         rsp.pending_count, e.pending_count));
                if (rsp.running_level !== e.running_level)
                    flag_error($sformatf("running_level %0d, want %0d",
                                         rsp.running_level, e.running_level));
                if (e.dispatch_valid)
                    dispatch_seen++;
                status_seen[e.status]++;
            end
        end
    end

    // finish while idle, extreme levels and ids, finish that dispatches
    task automatic test_idle_finish();
        send_event(make_event(OP_FINISH, 8'hFF, 8'hFF));
        send_event(make_event(OP_ADD, 8'hFF, 8'd255));
        send_event(make_event(OP_ADD, 8'h00, 8'd0));
        send_event(make_event(OP_FINISH, 8'h00, 8'h00));
        send_event(make_event(OP_ADD, 8'h5A, 8'd255));
        send_event(make_event(OP_FINISH, 8'hA5, 8'h3C));
        send_event(make_event(OP_FINISH, 8'h00, 8'h00));
        send_event(make_event(OP_FINISH, 8'h00, 8'h00));
        wait_drained();
    endtask

    // strictly decreasing levels fill the nesting stack
    task automatic test_nest_full();
        for (int i = 0; i < ND; i++)
            send_event(make_event(OP_ADD, 8'(8'h10 + i), 8'(100 - i)));
        send_event(make_event(OP_ADD, 8'h77, 8'd50));
        wait_drained();
    endtask

    // equal levels keep arrival order; a full queue drops the add
    task automatic test_queue_full();
        for (int i = 0; i < QD - 1; i++)
            send_event(make_event(OP_ADD, 8'(8'hC0 + i), 8'd200));
        send_event(make_event(OP_ADD, 8'hEE, 8'd1));
        send_event(make_event(OP_FINISH, 8'h00, 8'h00));
        wait_drained();
    endtask

    // random add and finish mix with a given share of adds
    task automatic test_random_traffic(input int n_items, input int add_pct);
        logic op;
        for (int i = 0; i < n_items; i++)
        begin
            op = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_FINISH;
            send_event(make_event(op, 8'($urandom_range(0, 255)), pick_level()));
        end
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        error_count  = 0;
        items_sent   = 0;
        dispatch_seen = 0;
        status_seen  = '{default: 0};
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        shadow_count = 0;
        shadow_depth = 0;
        shadow_run_level = IDLE_LEVEL;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_finish();
        test_nest_full();
        test_queue_full();

        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        test_random_traffic(60, 70);
        test_random_traffic(60, 35);
        wait_drained();
        test_random_traffic(60, 55);
        test_random_traffic(60, 45);

        // last stretch at full rate
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        test_random_traffic(80, 60);
        test_random_traffic(80, 45);

        wait_drained();
        repeat (20) @(posedge clk);

        $display("covered %0d items, %0d dispatches", items_sent, dispatch_seen);
        $display("status counts: ok %0d, queue full %0d, idle finish %0d, nest full %0d",
                 status_seen[ST_OK], status_seen[ST_QUEUE_FULL],
                 status_seen[ST_IDLE_FIN], status_seen[ST_NEST_FULL]);
        if (error_count == 0 && expected_dispatch_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
